// ===== sv/cfwk_pkg.sv =====
// ----------------------------------------------------------------------------
// cfwk_pkg
// Shared types and codes for the circular key FIFO with lookup.
// ----------------------------------------------------------------------------
package cfwk_pkg;

    localparam int KEY_W = 32;
    localparam int OCC_W = 8;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_LOOKUP = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_DUP   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HREAD,
        S_HDATA,
        S_DONE
    } state_t;

    // Port controls from the sequencer to the key store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    // One finished result, handed from the sequencer to the output register.
    typedef struct packed {
        logic [KEY_W-1:0] out_key;
        status_t          status;
        logic             found;
        logic [OCC_W-1:0] occupancy;
        logic             is_empty;
        logic             is_full;
    } result_t;

endpackage

// ===== sv/cfwk_store.sv =====
// ----------------------------------------------------------------------------
// cfwk_store
// Key storage RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cfwk_store
    import cfwk_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic             aclk,
    input  mem_ctl_t         ctl,
    input  logic [AW-1:0]    wr_addr,
    input  logic [KEY_W-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [KEY_W-1:0] rd_data
);

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/cfwk_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfwk_ctrl
// Sequencer: ring pointers, occupancy, and the shared key comparator that
// walks the held entries one per cycle for push and lookup.
// ----------------------------------------------------------------------------
module cfwk_ctrl
    import cfwk_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int CW    = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_fire,
    input  logic [1:0]       in_cmd,
    input  logic [KEY_W-1:0] in_key,
    output logic             in_ready,
    output mem_ctl_t         mem_ctl,
    output logic [AW-1:0]    wr_addr,
    output logic [KEY_W-1:0] wr_data,
    output logic [AW-1:0]    rd_addr,
    input  logic [KEY_W-1:0] rd_data,
    output logic             res_valid,
    input  logic             res_take,
    output result_t          res
);

    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        logic [AW-1:0] n;
        n = (p == LAST_SLOT) ? '0 : p + AW'(1);
        return n;
    endfunction

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [AW-1:0]    scan_ptr_reg, scan_ptr_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic             hit_reg, hit_next;
    logic [KEY_W-1:0] rkey_reg, rkey_next;

    logic             is_full_now;
    logic [CW-1:0]    cnt_after;
    logic             do_write;
    logic             do_advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= LAST_SLOT;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        idx_reg      <= idx_next;
        scan_ptr_reg <= scan_ptr_next;
        hit_reg      <= hit_next;
        rkey_reg     <= rkey_next;
    end

    assign is_full_now = (count_reg == FULL_CNT);

    // Result and the state change it implies, valid while in S_DONE.
    always_comb begin
        res           = '0;
        res.status    = ST_OK;
        cnt_after     = count_reg;
        do_write      = 1'b0;
        do_advance    = 1'b0;
        unique case (cmd_reg)
            CMD_PUSH: begin
                if (hit_reg) begin
                    res.status = ST_DUP;
                    res.found  = 1'b1;
                end else if (is_full_now) begin
                    res.status = ST_FULL;
                end else begin
                    do_write  = 1'b1;
                    cnt_after = count_reg + CW'(1);
                end
            end
            CMD_POP: begin
                if (count_reg == '0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.out_key = rkey_reg;
                    do_advance  = 1'b1;
                    cnt_after   = count_reg - CW'(1);
                end
            end
            CMD_PEEK: begin
                if (count_reg == '0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.out_key = rkey_reg;
                end
            end
            CMD_LOOKUP: begin
                res.found = hit_reg;
            end
            default: begin
                res.status = ST_OK;
            end
        endcase
        res.occupancy = OCC_W'(cnt_after);
        res.is_empty  = (cnt_after == '0);
        res.is_full   = (cnt_after == FULL_CNT);
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        scan_ptr_next  = scan_ptr_reg;
        cmp_valid_next = 1'b0;
        hit_next       = hit_reg;
        rkey_next      = rkey_reg;
        mem_ctl        = '0;
        rd_addr        = head_reg;
        wr_addr        = wrap_inc(tail_reg);
        wr_data        = key_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_fire) begin
                    cmd_next      = cmd_t'(in_cmd);
                    key_next      = in_key;
                    idx_next      = '0;
                    scan_ptr_next = head_reg;
                    hit_next      = 1'b0;
                    if (cmd_t'(in_cmd) == CMD_PUSH || cmd_t'(in_cmd) == CMD_LOOKUP) begin
                        state_next = S_SCAN;
                    end else if (count_reg == '0) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_HREAD;
                    end
                end
            end
            S_SCAN: begin
                // Reads are issued back to back; each compare lands in the cycle after its read.
                rd_addr = scan_ptr_reg;
                if (idx_reg != count_reg) begin
                    mem_ctl.rd_en  = 1'b1;
                    cmp_valid_next = 1'b1;
                    idx_next       = idx_reg + CW'(1);
                    scan_ptr_next  = wrap_inc(scan_ptr_reg);
                end else if (!cmp_valid_reg) begin
                    state_next = S_DONE;
                end
                if (cmp_valid_reg && rd_data == key_reg) begin
                    hit_next = 1'b1;
                end
            end
            S_HREAD: begin
                mem_ctl.rd_en = 1'b1;
                state_next    = S_HDATA;
            end
            S_HDATA: begin
                rkey_next  = rd_data;
                state_next = S_DONE;
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_take) begin
                    mem_ctl.wr_en = do_write;
                    count_next    = cnt_after;
                    if (do_write) begin
                        tail_next = wrap_inc(tail_reg);
                    end
                    if (do_advance) begin
                        head_next = wrap_inc(head_reg);
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/circular_fifo_with_key_lookup.sv =====
// ----------------------------------------------------------------------------
// circular_fifo_with_key_lookup
// Ring-buffer FIFO of 32-bit keys with duplicate rejection on push and
// a key lookup that walks the held entries from oldest to newest.
// ----------------------------------------------------------------------------
//  Channel   Ports                                   Direction
//  input     s_valid s_ready s_cmd s_key             in (s_ready out)
//  result    m_valid m_ready m_out_key m_status      out (m_ready in)
//            m_found m_occupancy m_is_empty m_is_full
//
// Push and lookup compare one stored key per cycle through the single RAM
// read port, and the last compare comes in the cycle after its read. Pop and
// peek read only the head entry, and skip the read when the queue is empty.
// A stalled result sits in the output register; the next transaction is
// accepted meanwhile, but the one after it waits for that register to drain.
// Reset idles the sequencer, resets pointers, occupancy and output valid; the key RAM is not cleared.
// ----------------------------------------------------------------------------
module circular_fifo_with_key_lookup
    import cfwk_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_cmd,
    input  logic [KEY_W-1:0]    s_key,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [KEY_W-1:0]    m_out_key,
    output logic [1:0]          m_status,
    output logic                m_found,
    output logic [OCC_W-1:0]    m_occupancy,
    output logic                m_is_empty,
    output logic                m_is_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mem_ctl_t         mem_ctl;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic [KEY_W-1:0] wr_data;
    logic [KEY_W-1:0] rd_data;
    logic             in_fire;
    logic             res_valid;
    logic             out_free;
    result_t          res;

    logic             m_valid_reg, m_valid_next;
    result_t          res_reg;

    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    cfwk_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_cmd    (s_cmd),
        .in_key    (s_key),
        .in_ready  (s_ready),
        .mem_ctl   (mem_ctl),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_take  (out_free),
        .res       (res)
    );

    cfwk_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && out_free) begin
            res_reg <= res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_key   = res_reg.out_key;
    assign m_status    = res_reg.status;
    assign m_found     = res_reg.found;
    assign m_occupancy = res_reg.occupancy;
    assign m_is_empty  = res_reg.is_empty;
    assign m_is_full   = res_reg.is_full;

`ifndef ASSERT_OFF
    // The sequencer is not ready in the cycle after every accepted transaction.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_ready)
        else $error("input accepted again in the cycle after a transaction");

    // A refused duplicate push always reports the key as found.
    a_dup_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_DUP) |-> m_found)
        else $error("duplicate status without found flag");

    // An empty refusal leaves the queue empty and returns no key.
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_EMPTY) |-> (m_is_empty && m_out_key == '0))
        else $error("empty status with stale key or nonzero occupancy");

    // Full and empty flags never agree.
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_is_full && m_is_empty))
        else $error("full and empty flags both set");
`endif

endmodule
